>>> hw/rtl/ffar_pkg.sv
// ----------------------------------------------------------------------------
// ffar_pkg
// Shared types and constants of the first-fit aligned range allocator.
// ----------------------------------------------------------------------------
package ffar_pkg;

  localparam int unsigned OFF_W     = 41;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned ALIGN_W   = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BYTES  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_ALIGN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_OFF = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd5;

  // One range: used for free table entries and live allocations.
  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
  } range_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN
  } shift_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FS_RD,
    S_FS_CHK,
    S_FS_MOD,
    S_FS_FIT,
    S_SLOT,
    S_AS_RD,
    S_AS_CMP,
    S_RP_RD,
    S_RP_CMP,
    S_PLAN,
    S_SH_RD,
    S_SH_WR,
    S_WA,
    S_WB,
    S_DONE
  } state_e;

  // Handshake between the sequencer and the remainder unit.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [ALIGN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [ALIGN_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> hw/rtl/first_fit_aligned_range_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_aligned_range_allocator_top
// First-fit allocator over one arena: sorted free-range table and allocation
// table in synchronous memories, walked by one sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | sink      | in_valid_i/in_ready_o, mode, request_size, align, offset
//  out     | source    | out_valid_o/out_ready_i, status, granted_offset/size
//  cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// One item at a time. Allocate runs the 64-step remainder unit on each free
// range it tries, then checks allocation slots in turn for a free one, then
// moves free entries. Release reads and compares allocation slots, then free
// entries, then moves free entries.
// After reset and after an arena_bytes write the first free entry is written
// before input is taken. A waiting result does not block the
// next transfer in; a result waits in S_DONE only while the output is full.
module first_fit_aligned_range_allocator_top
  import ffar_pkg::*;
#(
  parameter int unsigned MAX_FREE_RANGES = 32,
  parameter int unsigned MAX_ALLOCATIONS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [OFF_W-1:0]     request_size_i,
  input  logic [ALIGN_W-1:0]   align_bytes_i,
  input  logic [OFF_W-1:0]     slice_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OFF_W-1:0]     granted_offset_o,
  output logic [OFF_W-1:0]     granted_size_o
);

  localparam int unsigned FIDX_W = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CNT_W  = $clog2(MAX_FREE_RANGES + 1);
  localparam int unsigned SLOT_W = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam logic [CNT_W-1:0]  FREE_MAX  = CNT_W'(MAX_FREE_RANGES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_ALLOCATIONS - 1);

  // memories
  range_t free_mem [MAX_FREE_RANGES];
  range_t alloc_mem [MAX_ALLOCATIONS];
  range_t f_rd_q, a_rd_q;
  logic              f_re, f_we, a_re, a_we;
  logic [FIDX_W-1:0] f_raddr, f_waddr;
  logic [SLOT_W-1:0] a_raddr, a_waddr;
  range_t            f_wdata, a_wdata;

  always_ff @(posedge clk_i) begin
    if (f_re) f_rd_q <= free_mem[f_raddr];
    if (f_we) free_mem[f_waddr] <= f_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (a_re) a_rd_q <= alloc_mem[a_raddr];
    if (a_we) alloc_mem[a_waddr] <= a_wdata;
  end

  // configuration
  logic              cfg_wr, base_wr, arena_wr;
  logic [ADDR_W-1:0] base_q;
  logic [OFF_W-1:0]  arena_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign base_wr     = cfg_wr && (cfg_index_i == CFG_BASE_ADDRESS);
  assign arena_wr    = cfg_wr && (cfg_index_i == CFG_ARENA_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      arena_q <= OFF_W'(1);
    end else begin
      if (base_wr)  base_q  <= cfg_data_i;
      if (arena_wr) arena_q <= cfg_data_i[OFF_W-1:0];
    end
  end

  // remainder unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  ffar_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // sequencer state
  state_e state_q, state_d;
  logic   init_pend_q, init_pend_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [MAX_ALLOCATIONS-1:0] valid_q;
  logic              vset, vclr;
  logic [SLOT_W-1:0] vslot;

  logic               mode_q, mode_d;
  logic [OFF_W-1:0]   size_q, size_d;
  logic [ALIGN_W-1:0] align_q, align_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  range_t             ent_a_q, ent_a_d;   // candidate range, or left neighbor
  range_t             ent_b_q, ent_b_d;   // right neighbor
  range_t             ent_r_q, ent_r_d;   // range being released
  logic               has_next_q, has_next_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ALIGN_W-1:0] pad_q, pad_d;

  shift_e             sh_q, sh_d;
  logic [CNT_W-1:0]   sh_p_q, sh_p_d;
  logic               wa_en_q, wa_en_d, wb_en_q, wb_en_d;
  logic [FIDX_W-1:0]  wa_addr_q, wa_addr_d, wb_addr_q, wb_addr_d;
  range_t             wa_q, wa_d, wb_q, wb_d;
  logic [CNT_W-1:0]   cnt_new_q, cnt_new_d;

  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic [OFF_W-1:0]    res_off_q, res_off_d, res_size_q, res_size_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [OFF_W-1:0]    out_off_q, out_off_d, out_size_q, out_size_d;

  // datapath terms
  logic [ADDR_W:0]  abs_sum, pad_sum;
  logic [ALIGN_W-1:0] pad_val;
  logic [OFF_W-1:0] pad_ext, aoff, aend, len_left;
  logic [OFF_W:0]   pad_size, prev_end, rel_end;
  logic             fits, need_pre, need_suf, merge_prev, merge_next;

  assign abs_sum  = {1'b0, base_q} + {{(ADDR_W - OFF_W + 1){1'b0}}, f_rd_q.start};
  assign pad_val  = (mod_rsp.rem == '0) ? '0 : ALIGN_W'(align_q - mod_rsp.rem);
  assign pad_sum  = {1'b0, addr_q} + {{(ADDR_W - ALIGN_W + 1){1'b0}}, pad_q};
  assign pad_ext  = {{(OFF_W - ALIGN_W){1'b0}}, pad_q};
  assign len_left = ent_a_q.len - pad_ext;
  assign fits     = !pad_sum[ADDR_W] && (pad_ext <= ent_a_q.len) && (size_q <= len_left);
  assign aoff     = ent_a_q.start + pad_ext;
  assign aend     = aoff + size_q;
  assign pad_size = {1'b0, pad_ext} + {1'b0, size_q};
  assign need_pre = pad_q != '0;
  assign need_suf = pad_size != {1'b0, ent_a_q.len};
  assign prev_end = {1'b0, ent_a_q.start} + {1'b0, ent_a_q.len};
  assign rel_end  = {1'b0, ent_r_q.start} + {1'b0, ent_r_q.len};
  assign merge_prev = (idx_q != '0) && (prev_end == {1'b0, ent_r_q.start});
  assign merge_next = has_next_q && (rel_end == {1'b0, ent_b_q.start});

  assign in_ready_o = (state_q == S_IDLE) && !init_pend_q;

  always_comb begin
    state_d     = state_q;
    init_pend_d = init_pend_q;
    count_d     = count_q;
    mode_d      = mode_q;
    size_d      = size_q;
    align_d     = align_q;
    off_d       = off_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    ent_a_d     = ent_a_q;
    ent_b_d     = ent_b_q;
    ent_r_d     = ent_r_q;
    has_next_d  = has_next_q;
    addr_d      = addr_q;
    pad_d       = pad_q;
    sh_d        = sh_q;
    sh_p_d      = sh_p_q;
    wa_en_d     = wa_en_q;
    wa_addr_d   = wa_addr_q;
    wa_d        = wa_q;
    wb_en_d     = wb_en_q;
    wb_addr_d   = wb_addr_q;
    wb_d        = wb_q;
    cnt_new_d   = cnt_new_q;
    res_st_d    = res_st_q;
    res_off_d   = res_off_q;
    res_size_d  = res_size_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_off_d   = out_off_q;
    out_size_d  = out_size_q;

    f_re    = 1'b0;
    f_raddr = '0;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    a_re    = 1'b0;
    a_raddr = slot_q;
    a_we    = 1'b0;
    a_waddr = slot_q;
    a_wdata = '0;
    vset    = 1'b0;
    vclr    = 1'b0;
    vslot   = slot_q;

    mod_req.start    = 1'b0;
    mod_req.dividend = abs_sum[ADDR_W-1:0];
    mod_req.divisor  = align_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (init_pend_q) begin
          // first free entry covers the whole arena
          f_we        = 1'b1;
          f_waddr     = '0;
          f_wdata     = '{start: '0, len: arena_q};
          init_pend_d = 1'b0;
        end else if (in_valid_i) begin
          mode_d     = mode_i;
          size_d     = request_size_i;
          align_d    = align_bytes_i;
          off_d      = slice_offset_i;
          idx_d      = '0;
          slot_d     = '0;
          has_next_d = 1'b0;
          res_st_d   = ST_OK;
          res_off_d  = '0;
          res_size_d = '0;
          sh_d       = SH_NONE;
          wa_en_d    = 1'b0;
          wb_en_d    = 1'b0;
          cnt_new_d  = count_q;
          if (mode_i) begin
            state_d = S_AS_RD;
          end else if (request_size_i == '0) begin
            res_st_d = ST_ZERO_SIZE;
            state_d  = S_DONE;
          end else if (align_bytes_i == '0) begin
            res_st_d = ST_ZERO_ALIGN;
            state_d  = S_DONE;
          end else begin
            state_d = S_FS_RD;
          end
        end
      end

      S_FS_RD: begin
        if (idx_q >= count_q) begin
          res_st_d = ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          f_re    = 1'b1;
          f_raddr = idx_q[FIDX_W-1:0];
          state_d = S_FS_CHK;
        end
      end

      S_FS_CHK: begin
        ent_a_d = f_rd_q;
        if (abs_sum[ADDR_W]) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FS_RD;
        end else begin
          addr_d        = abs_sum[ADDR_W-1:0];
          mod_req.start = 1'b1;
          state_d       = S_FS_MOD;
        end
      end

      S_FS_MOD: begin
        if (mod_rsp.done) begin
          pad_d   = pad_val;
          state_d = S_FS_FIT;
        end
      end

      S_FS_FIT: begin
        if (fits) begin
          slot_d  = '0;
          state_d = S_SLOT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FS_RD;
        end
      end

      S_SLOT: begin
        if (!valid_q[slot_q]) begin
          if (need_pre && need_suf && (count_q >= FREE_MAX)) begin
            res_st_d = ST_TABLE_FULL;
            state_d  = S_DONE;
          end else begin
            a_we       = 1'b1;
            a_wdata    = '{start: aoff, len: size_q};
            vset       = 1'b1;
            res_st_d   = ST_OK;
            res_off_d  = aoff;
            res_size_d = size_q;
            wa_addr_d  = idx_q[FIDX_W-1:0];
            wb_addr_d  = FIDX_W'(idx_q + 1'b1);
            wb_d       = '{start: aend, len: OFF_W'(ent_a_q.len - pad_size[OFF_W-1:0])};
            state_d    = S_SH_RD;
            if (need_pre && need_suf) begin
              sh_d      = SH_UP;
              sh_p_d    = idx_q + 1'b1;
              idx_d     = count_q;
              wa_en_d   = 1'b1;
              wa_d      = '{start: ent_a_q.start, len: pad_ext};
              wb_en_d   = 1'b1;
              cnt_new_d = count_q + 1'b1;
            end else if (need_pre) begin
              wa_en_d = 1'b1;
              wa_d    = '{start: ent_a_q.start, len: pad_ext};
            end else if (need_suf) begin
              wa_en_d = 1'b1;
              wa_d    = wb_d;
            end else begin
              sh_d      = SH_DOWN;
              sh_p_d    = idx_q;
              cnt_new_d = count_q - 1'b1;
            end
          end
        end else if (slot_q == SLOT_LAST) begin
          res_st_d = ST_TABLE_FULL;
          state_d  = S_DONE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end

      S_AS_RD: begin
        a_re    = 1'b1;
        state_d = S_AS_CMP;
      end

      S_AS_CMP: begin
        if (valid_q[slot_q] && (a_rd_q.start == off_q)) begin
          ent_r_d = a_rd_q;
          idx_d   = '0;
          state_d = S_RP_RD;
        end else if (slot_q == SLOT_LAST) begin
          res_st_d = ST_UNKNOWN_OFF;
          state_d  = S_DONE;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_AS_RD;
        end
      end

      S_RP_RD: begin
        if (idx_q == count_q) begin
          state_d = S_PLAN;
        end else begin
          f_re    = 1'b1;
          f_raddr = idx_q[FIDX_W-1:0];
          state_d = S_RP_CMP;
        end
      end

      S_RP_CMP: begin
        if (f_rd_q.start < ent_r_q.start) begin
          ent_a_d = f_rd_q;
          idx_d   = idx_q + 1'b1;
          state_d = S_RP_RD;
        end else begin
          ent_b_d    = f_rd_q;
          has_next_d = 1'b1;
          state_d    = S_PLAN;
        end
      end

      S_PLAN: begin
        if (!merge_prev && !merge_next && (count_q >= FREE_MAX)) begin
          res_st_d = ST_TABLE_FULL;
          state_d  = S_DONE;
        end else begin
          vclr     = 1'b1;
          res_st_d = ST_OK;
          wa_en_d  = 1'b1;
          state_d  = S_SH_RD;
          if (merge_prev && merge_next) begin
            wa_addr_d = FIDX_W'(idx_q - 1'b1);
            wa_d      = '{start: ent_a_q.start,
                          len: OFF_W'(ent_a_q.len + ent_r_q.len + ent_b_q.len)};
            sh_d      = SH_DOWN;
            sh_p_d    = idx_q;
            cnt_new_d = count_q - 1'b1;
          end else if (merge_prev) begin
            wa_addr_d = FIDX_W'(idx_q - 1'b1);
            wa_d      = '{start: ent_a_q.start, len: OFF_W'(ent_a_q.len + ent_r_q.len)};
          end else if (merge_next) begin
            wa_addr_d = idx_q[FIDX_W-1:0];
            wa_d      = '{start: ent_r_q.start, len: OFF_W'(ent_r_q.len + ent_b_q.len)};
          end else begin
            wa_addr_d = idx_q[FIDX_W-1:0];
            wa_d      = ent_r_q;
            sh_d      = SH_UP;
            sh_p_d    = idx_q;
            idx_d     = count_q;
            cnt_new_d = count_q + 1'b1;
          end
        end
      end

      // idx_q walks the entries being moved
      S_SH_RD: begin
        case (sh_q)
          SH_DOWN: begin
            if (CNT_W'(idx_q + 1'b1) >= count_q) begin
              state_d = S_WA;
            end else begin
              f_re    = 1'b1;
              f_raddr = FIDX_W'(idx_q + 1'b1);
              state_d = S_SH_WR;
            end
          end
          SH_UP: begin
            if (idx_q <= sh_p_q) begin
              state_d = S_WA;
            end else begin
              f_re    = 1'b1;
              f_raddr = FIDX_W'(idx_q - 1'b1);
              state_d = S_SH_WR;
            end
          end
          default: state_d = S_WA;
        endcase
        if (sh_q == SH_DOWN && idx_q == sh_p_q && state_q == S_SH_RD) begin
          // start position already loaded in idx_q
        end
      end

      S_SH_WR: begin
        f_we    = 1'b1;
        f_waddr = idx_q[FIDX_W-1:0];
        f_wdata = f_rd_q;
        idx_d   = (sh_q == SH_UP) ? CNT_W'(idx_q - 1'b1) : CNT_W'(idx_q + 1'b1);
        state_d = S_SH_RD;
      end

      S_WA: begin
        f_we    = wa_en_q;
        f_waddr = wa_addr_q;
        f_wdata = wa_q;
        state_d = S_WB;
      end

      S_WB: begin
        f_we    = wb_en_q;
        f_waddr = wb_addr_q;
        f_wdata = wb_q;
        count_d = cnt_new_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_off_d   = res_off_q;
          out_size_d  = res_size_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_pend_q <= 1'b1;
      count_q     <= CNT_W'(1);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (arena_wr) begin
        init_pend_q <= 1'b1;
        count_q     <= (cfg_data_i[OFF_W-1:0] != '0) ? CNT_W'(1) : '0;
        valid_q     <= '0;
      end else begin
        init_pend_q <= init_pend_d;
        count_q     <= count_d;
        if (vset) valid_q[vslot] <= 1'b1;
        if (vclr) valid_q[vslot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    size_q     <= size_d;
    align_q    <= align_d;
    off_q      <= off_d;
    idx_q      <= (state_q == S_SLOT && sh_d == SH_DOWN) ? sh_p_d : idx_d;
    slot_q     <= slot_d;
    ent_a_q    <= ent_a_d;
    ent_b_q    <= ent_b_d;
    ent_r_q    <= ent_r_d;
    has_next_q <= has_next_d;
    addr_q     <= addr_d;
    pad_q      <= pad_d;
    sh_q       <= sh_d;
    sh_p_q     <= sh_p_d;
    wa_en_q    <= wa_en_d;
    wa_addr_q  <= wa_addr_d;
    wa_q       <= wa_d;
    wb_en_q    <= wb_en_d;
    wb_addr_q  <= wb_addr_d;
    wb_q       <= wb_d;
    cnt_new_q  <= cnt_new_d;
    res_st_q   <= res_st_d;
    res_off_q  <= res_off_d;
    res_size_q <= res_size_d;
    out_st_q   <= out_st_d;
    out_off_q  <= out_off_d;
    out_size_q <= out_size_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign granted_offset_o = out_off_q;
  assign granted_size_o   = out_size_q;

endmodule

>>> hw/rtl/ffar_mod.sv
// ----------------------------------------------------------------------------
// ffar_mod
// Bit-serial restoring remainder: 64-bit dividend modulo 32-bit divisor,
// one dividend bit per cycle, done pulse after 64 steps.
// ----------------------------------------------------------------------------
module ffar_mod
  import ffar_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(ADDR_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [ADDR_W-1:0]  dvd_q, dvd_d;
  logic [ALIGN_W-1:0] div_q, div_d;
  logic [ALIGN_W-1:0] rem_q, rem_d;
  logic [ALIGN_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[ADDR_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = ALIGN_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[ALIGN_W-1:0];
      end
      dvd_d  = {dvd_q[ADDR_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
